### rtl/lgi_pkg.sv
// Package for the LED gradient interpolator.
// Holds the shared types, state encoding and constants; no dependencies.
package lgi_pkg;

    localparam int LED_COUNT = 64;      // number of LED bins in the strip
    localparam int FILL_W    = 7;       // fill count width, holds 0 up to 64
    localparam int BIN_W     = 6;       // width of a bin index
    localparam int CHAN_W    = 8;       // width of one color channel
    localparam int DATA_W    = 40;      // packed tdata width, whole bytes

    // Channel 3 is red, 2 green, 1 blue, 0 alpha.
    typedef logic [3:0][CHAN_W-1:0] t_rgba;

    localparam t_rgba WHITE = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_LOAD,
        S_DIV_WAIT,
        S_RUN
    } t_state;

    // Control from the sequencer to the channel stepper.
    typedef struct packed {
        logic              load;    // start a run at base color
        t_rgba             base;
        logic [BIN_W-1:0]  gap;     // divisor of the run, 1 for flat runs
        logic              set;     // write the step of one channel
        logic [1:0]        ch;
        logic [CHAN_W-1:0] qd;      // floor(d / gap), modulo 256
        logic [BIN_W-1:0]  rd;      // d mod gap, in 0 .. gap-1
        logic              adv;     // move to the next bin
    } t_step_ctl;

endpackage

### rtl/lgi_divider.sv
// Iterative restoring divider: signed 9-bit difference over a 6-bit gap.
// Gives floor quotient and non-negative remainder; uses lgi_pkg.
module lgi_divider import lgi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [CHAN_W:0]  i_num,
    input  logic [BIN_W-1:0]        i_den,
    output logic                    o_done,
    output logic [CHAN_W-1:0]       o_quot,
    output logic [BIN_W-1:0]        o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [2:0]        r_cnt, n_cnt;
    logic [CHAN_W-1:0] r_quo, n_quo;
    logic [BIN_W-1:0]  r_rem, n_rem;
    logic [BIN_W-1:0]  r_den, n_den;
    logic              r_neg, n_neg;

    logic [CHAN_W:0]   w_negnum;
    logic [BIN_W:0]    w_trial;
    logic [BIN_W:0]    w_diff;
    logic              w_nz;
    logic [CHAN_W-1:0] w_qadj;

    always_comb begin
        w_negnum = (CHAN_W+1)'(0) - i_num;
        w_trial  = {r_rem, r_quo[CHAN_W-1]};
        w_diff   = w_trial - {1'b0, r_den};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_den  = i_den;
            n_neg  = i_num[CHAN_W];
            n_quo  = i_num[CHAN_W] ? w_negnum[CHAN_W-1:0] : i_num[CHAN_W-1:0];
        end else if (r_busy) begin
            // One quotient bit per cycle, shifted in as the dividend shifts out.
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_diff[BIN_W-1:0];
                n_quo = {r_quo[CHAN_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[BIN_W-1:0];
                n_quo = {r_quo[CHAN_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    // A negative dividend with a remainder rounds the quotient down by one more.
    always_comb begin
        w_nz   = (r_rem != '0);
        w_qadj = r_quo + {{(CHAN_W-1){1'b0}}, w_nz};
        o_quot = r_neg ? (~w_qadj + {{(CHAN_W-1){1'b0}}, 1'b1}) : r_quo;
        o_rem  = (r_neg && w_nz) ? (r_den - r_rem) : r_rem;
        o_done = r_done;
    end

endmodule

### rtl/lgi_stepper.sv
// Four channel lanes that step a color by quotient and remainder each bin.
// Keeps the running color and the remainder of every channel; uses lgi_pkg.
module lgi_stepper import lgi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_ctl i_ctl,
    output t_rgba     o_color
);

    logic [3:0][CHAN_W-1:0] r_val, n_val;
    logic [3:0][CHAN_W-1:0] r_qd, n_qd;
    logic [3:0][BIN_W-1:0]  r_rd, n_rd;
    logic [3:0][BIN_W-1:0]  r_acc, n_acc;
    logic [BIN_W-1:0]       r_gap, n_gap;
    logic [3:0][BIN_W:0]    w_sum;
    logic [3:0][BIN_W:0]    w_wrap;

    always_comb begin
        n_val = r_val;
        n_qd  = r_qd;
        n_rd  = r_rd;
        n_acc = r_acc;
        n_gap = r_gap;
        for (int c = 0; c < 4; c++) begin
            w_sum[c]  = {1'b0, r_acc[c]} + {1'b0, r_rd[c]};
            w_wrap[c] = w_sum[c] - {1'b0, r_gap};
        end
        if (i_ctl.load) begin
            n_val = i_ctl.base;
            n_qd  = '0;
            n_rd  = '0;
            n_acc = '0;
            n_gap = i_ctl.gap;
        end else if (i_ctl.set) begin
            n_qd[i_ctl.ch] = i_ctl.qd;
            n_rd[i_ctl.ch] = i_ctl.rd;
        end else if (i_ctl.adv) begin
            // The remainder carries one extra unit into the color when it wraps.
            for (int c = 0; c < 4; c++) begin
                if (w_sum[c] >= {1'b0, r_gap}) begin
                    n_acc[c] = w_wrap[c][BIN_W-1:0];
                    n_val[c] = r_val[c] + r_qd[c] + {{(CHAN_W-1){1'b0}}, 1'b1};
                end else begin
                    n_acc[c] = w_sum[c][BIN_W-1:0];
                    n_val[c] = r_val[c] + r_qd[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= {{(BIN_W-1){1'b0}}, 1'b1};
        end else begin
            r_gap <= n_gap;
        end
        r_val <= n_val;
        r_qd  <= n_qd;
        r_rd  <= n_rd;
        r_acc <= n_acc;
    end

    assign o_color = r_val;

endmodule

### rtl/led_gradient_interpolator.sv
// LED gradient interpolator: keyframes in, one RGBA color per LED bin out.
// A flat run (first keyframe or finish) goes from idle straight to the run state.
// An interpolated run first divides each channel difference by the gap on the shared
// divider, one channel after another, before its first bin. Bins then leave at one
// per cycle while the receiver is ready; a new keyframe is taken once its run has ended.
// Reset (synchronous, active low) clears the fill count and sets the last color to white.
module led_gradient_interpolator import lgi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,  // key_index, key_red, key_green, key_blue, key_alpha
    input  logic [0:0]        i_s_tuser,  // func
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,  // bin_index, out_red, out_green, out_blue, out_alpha
    output logic              o_m_tlast   // run_last
);

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_filled, n_filled;
    t_rgba               r_prev, n_prev;
    logic                r_seen, n_seen;
    logic [FILL_W-1:0]   r_bin, n_bin;
    logic [FILL_W-1:0]   r_end, n_end;
    logic [1:0]          r_ch, n_ch;
    logic [BIN_W-1:0]    r_gap, n_gap;
    t_rgba               r_key, n_key;
    t_rgba               r_base, n_base;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_last, n_out_last;

    logic                w_fire;
    logic                w_emit;
    logic [BIN_W-1:0]    w_idx;
    t_rgba               w_key;
    logic [FILL_W-1:0]   w_idx_ext;
    logic [FILL_W-1:0]   w_idx_inc;
    logic [FILL_W-1:0]   w_led;
    logic [FILL_W-1:0]   w_bin_inc;
    logic                w_last;
    logic signed [CHAN_W:0] w_num;
    logic                w_div_start;
    logic                w_div_done;
    logic [CHAN_W-1:0]   w_div_quot;
    logic [BIN_W-1:0]    w_div_rem;
    t_step_ctl           w_ctl;
    t_rgba               w_color;

    assign w_idx     = i_s_tdata[5:0];
    assign w_key     = {i_s_tdata[13:6], i_s_tdata[21:14], i_s_tdata[29:22], i_s_tdata[37:30]};
    assign w_idx_ext = {1'b0, w_idx};
    assign w_idx_inc = w_idx_ext + {{(FILL_W-1){1'b0}}, 1'b1};
    assign w_led     = FILL_W'(LED_COUNT);
    assign w_bin_inc = r_bin + {{(FILL_W-1){1'b0}}, 1'b1};
    assign w_last    = (w_bin_inc == r_end);
    assign w_num     = $signed({1'b0, r_key[r_ch]}) - $signed({1'b0, r_base[r_ch]});

    assign o_s_tready = (r_state == S_IDLE);
    assign w_fire     = i_s_tvalid && o_s_tready;
    assign w_emit     = (r_state == S_RUN) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_filled    = r_filled;
        n_prev      = r_prev;
        n_seen      = r_seen;
        n_bin       = r_bin;
        n_end       = r_end;
        n_ch        = r_ch;
        n_gap       = r_gap;
        n_key       = r_key;
        n_base      = r_base;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        w_div_start = 1'b0;
        w_ctl       = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    n_key    = w_key;
                    n_base   = r_prev;
                    w_ctl.gap = {{(BIN_W-1){1'b0}}, 1'b1};
                    if (i_s_tuser[0]) begin
                        // Finish: pad with the last color, then start over.
                        w_ctl.load = 1'b1;
                        w_ctl.base = r_prev;
                        n_bin      = r_filled;
                        n_end      = w_led;
                        n_state    = (r_filled < w_led) ? S_RUN : S_IDLE;
                        n_filled   = '0;
                        n_prev     = WHITE;
                        n_seen     = 1'b0;
                    end else if (!r_seen) begin
                        w_ctl.load = 1'b1;
                        w_ctl.base = w_key;
                        n_bin      = '0;
                        n_end      = (w_idx_inc < w_led) ? w_idx_inc : w_led;
                        n_state    = S_RUN;
                        n_filled   = w_idx_inc;
                        n_prev     = w_key;
                        n_seen     = 1'b1;
                    end else begin
                        n_prev = w_key;
                        // An index at or below the fill count only updates the color.
                        if (w_idx_ext > r_filled) begin
                            n_gap      = w_idx - r_filled[BIN_W-1:0];
                            w_ctl.load = 1'b1;
                            w_ctl.base = r_prev;
                            w_ctl.gap  = n_gap;
                            n_bin      = r_filled;
                            n_end      = (w_idx_ext < w_led) ? w_idx_ext : w_led;
                            n_filled   = w_idx_ext;
                            n_ch       = '0;
                            n_state    = (r_filled < n_end) ? S_DIV_LOAD : S_IDLE;
                        end
                    end
                end
            end
            S_DIV_LOAD: begin
                w_div_start = 1'b1;
                n_state     = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    w_ctl.set = 1'b1;
                    w_ctl.ch  = r_ch;
                    w_ctl.qd  = w_div_quot;
                    w_ctl.rd  = w_div_rem;
                    if (r_ch == 2'd3) begin
                        n_state = S_RUN;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = S_DIV_LOAD;
                    end
                end
            end
            S_RUN: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, w_color[0], w_color[1], w_color[2], w_color[3],
                                   r_bin[BIN_W-1:0]};
                    n_out_last  = w_last;
                    w_ctl.adv   = 1'b1;
                    n_bin       = w_bin_inc;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_prev      <= WHITE;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_prev      <= n_prev;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            r_ch        <= n_ch;
        end
        r_bin      <= n_bin;
        r_end      <= n_end;
        r_gap      <= n_gap;
        r_key      <= n_key;
        r_base     <= n_base;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    lgi_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_gap),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem)
    );

    lgi_stepper u_stepper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_color (w_color)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_bin < r_end))
        else $error("run bin has passed the end of its run");

    a_bin_on_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[5:0] < w_led[BIN_W:0]))
        else $error("emitted bin lies beyond the strip");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_div_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV_LOAD) || (r_state == S_DIV_WAIT)) |-> (r_gap != '0))
        else $error("division set up with a zero gap");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_s_tuser[0]) |=> (!r_seen && (r_filled == '0)))
        else $error("finish did not restart the strip");
`endif

endmodule

### tb/sv/led_gradient_interpolator_tb.sv
// Self-checking testbench for the LED gradient interpolator: keyframes and finish
// transactions in, one color per LED bin out, checked against a built-in predictor.
// Depends on lgi_pkg and led_gradient_interpolator.
`timescale 1ns / 100ps

module led_gradient_interpolator_tb;
    import lgi_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 8;
    localparam int TOTAL_ITEMS  = 116;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int MAX_PRINTS   = 60;

    typedef enum logic {
        FN_KEY,
        FN_FINISH
    } t_func;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    typedef struct {
        t_func            func;
        logic [BIN_W-1:0] idx;
        t_rgba            color;
    } t_key_item;

    typedef struct {
        logic [BIN_W-1:0] bin;
        t_rgba            color;
        logic             last;
    } t_led_bin;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              s_valid   = 1'b0;
    logic [DATA_W-1:0] s_data    = '0;   // key_index, red, green, blue, alpha
    logic [0:0]        s_user    = '0;   // func
    logic              m_ready   = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [DATA_W-1:0] m_data;           // bin_index, red, green, blue, alpha
    logic              m_last;           // run_last

    led_gradient_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tlast  (m_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    t_key_item pending_keys[$];
    t_led_bin  expected_bins[$];
    int        error_count = 0;
    int        bins_seen   = 0;
    int        cycle_count = 0;

    // Predictor state, mirroring the block's fill count, last color and first-key flag.
    int        pred_fill  = 0;
    t_rgba     pred_color = WHITE;
    logic      pred_seen  = 1'b0;

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_bin(input int bin, input t_rgba color, input logic last);
        t_led_bin b;
        b.bin   = bin[BIN_W-1:0];
        b.color = color;
        b.last  = last;
        expected_bins.insert(expected_bins.size(), b);
    endtask

    task automatic predict_bins(input t_key_item k);
        int    gap;
        int    diff;
        int    num;
        int    quo;
        t_rgba mix;
        if (k.func == FN_FINISH) begin
            for (int b = pred_fill; b < LED_COUNT; b++)
                push_bin(b, pred_color, b == LED_COUNT - 1);
            pred_fill  = 0;
            pred_color = WHITE;
            pred_seen  = 1'b0;
        end else if (!pred_seen) begin
            for (int b = 0; b <= int'(k.idx); b++)
                push_bin(b, k.color, b == int'(k.idx));
            pred_fill  = int'(k.idx) + 1;
            pred_seen  = 1'b1;
            pred_color = k.color;
        end else begin
            if (int'(k.idx) > pred_fill) begin
                gap = int'(k.idx) - pred_fill;
                for (int j = 0; j < gap; j++) begin
                    for (int ch = 0; ch < 4; ch++) begin
                        diff = int'(k.color[ch]) - int'(pred_color[ch]);
                        num  = j * diff;
                        quo  = num / gap;
                        // Division truncates toward zero; step down for a negative remainder.
                        if (num < 0 && (num % gap) != 0)
                            quo--;
                        mix[ch] = 8'(int'(pred_color[ch]) + quo);
                    end
                    push_bin(pred_fill + j, mix, j == gap - 1);
                end
                pred_fill = int'(k.idx);
            end
            pred_color = k.color;
        end
    endtask

    // Channels are mostly random, with the extremes mixed in often.
    function automatic t_rgba rand_color();
        t_rgba c;
        for (int ch = 0; ch < 4; ch++) begin
            case ($urandom_range(0, 5))
                0:       c[ch] = 8'h00;
                1:       c[ch] = 8'hFF;
                default: c[ch] = 8'($urandom);
            endcase
        end
        return c;
    endfunction

    task automatic add_key(input int idx, input t_rgba color);
        t_key_item k;
        k.func  = FN_KEY;
        k.idx   = idx[BIN_W-1:0];
        k.color = color;
        pending_keys.insert(pending_keys.size(), k);
    endtask

    task automatic add_finish();
        t_key_item k;
        k.func  = FN_FINISH;
        k.idx   = 6'($urandom);
        k.color = rand_color();
        pending_keys.insert(pending_keys.size(), k);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int        gap_left   = 0;
    int        burst_left = 0;
    t_key_item next_key;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid    <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_keys.size() != 0) begin
                next_key = pending_keys.pop_front();
                s_data   <= {{(DATA_W - BIN_W - 4 * CHAN_W){1'b0}}, next_key.color[0],
                             next_key.color[1], next_key.color[2], next_key.color[3],
                             next_key.idx};
                s_user   <= next_key.func;
                s_valid  <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches between modes, plus one long hold-off.
    t_rx_mode rx_mode   = RX_STREAM;
    int       mode_left = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            mode_left <= 0;
            hold_left <= 0;
        end else if (!hold_done && bins_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(16, 160);
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_STREAM: m_ready <= 1'b1;
                RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Monitor: predicts on each accepted keyframe and checks each accepted bin.
    t_led_bin  want;
    t_key_item seen_key;
    string     chan_names[4] = '{"alpha", "blue", "green", "red"};

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pred_fill  = 0;
            pred_color = WHITE;
            pred_seen  = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                seen_key.func = t_func'(s_user[0]);
                seen_key.idx  = s_data[BIN_W-1:0];
                for (int ch = 0; ch < 4; ch++)
                    seen_key.color[ch] = s_data[BIN_W + (3 - ch) * CHAN_W +: CHAN_W];
                predict_bins(seen_key);
            end
            if (m_valid && m_ready) begin
                bins_seen <= bins_seen + 1;
                if (expected_bins.size() == 0) begin
                    report_mismatch($sformatf("bin %0d arrived with nothing expected",
                                              m_data[BIN_W-1:0]));
                end else begin
                    want = expected_bins.pop_front();
                    if (m_data[BIN_W-1:0] !== want.bin)
                        report_mismatch($sformatf("bin_index %0d, expected %0d",
                                                  m_data[BIN_W-1:0], want.bin));
                    for (int ch = 0; ch < 4; ch++) begin
                        if (m_data[BIN_W + (3 - ch) * CHAN_W +: CHAN_W] !== want.color[ch])
                            report_mismatch($sformatf("bin %0d %s %0d, expected %0d",
                                want.bin, chan_names[ch],
                                m_data[BIN_W + (3 - ch) * CHAN_W +: CHAN_W], want.color[ch]));
                    end
                    if (m_last !== want.last)
                        report_mismatch($sformatf("bin %0d run_last %b, expected %b",
                                                  want.bin, m_last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    int fill_guess;
    int first_idx;
    int key_idx;

    initial begin
        // Directed part.
        add_finish();                                  // no keyframes: all white
        add_key(0, 32'h00000000);
        add_key(63, 32'hFF00FF00);                     // long ramp from black
        add_finish();                                  // pads the single last bin
        add_key(63, 32'h80FF0001);                     // first key fills the whole strip
        add_finish();                                  // strip already full
        add_key(10, 32'hAA5500FF);
        add_key(11, 32'h12345678);                     // index equal to fill count
        add_key(5, 32'hFF008001);                      // out of order
        add_key(40, 32'h00FF7F80);                     // mixed rising and falling channels
        add_key(41, 32'hFFFFFFFF);
        add_key(41, 32'h00000000);                     // empty gap again
        add_finish();
        add_key(2, 32'hFF00FF00);
        add_key(0, 32'h00FF00FF);                      // out of order, color still taken
        add_key(62, 32'hFF00FF00);
        add_key(63, 32'h7F80017E);
        add_finish();
        add_key(0, 32'hFFFFFFFF);
        add_key(0, 32'h00000000);
        add_key(3, 32'hFF00FF00);                      // short gap
        add_finish();

        // Random part: mostly well-formed keyframe sequences, some noise.
        while (pending_keys.size() < TOTAL_ITEMS) begin
            case ($urandom_range(0, 9))
                0: add_finish();
                1: add_key($urandom_range(0, 63), rand_color());
                default: begin
                    first_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(0, 8);
                    add_key(first_idx, rand_color());
                    fill_guess = first_idx + 1;
                    repeat ($urandom_range(1, 5)) begin
                        case ($urandom_range(0, 7))
                            0:       key_idx = $urandom_range(0, 63);
                            1:       key_idx = (fill_guess > 63) ? 63 : fill_guess;
                            default: key_idx = fill_guess + $urandom_range(1, 24);
                        endcase
                        if (key_idx > 63)
                            key_idx = 63;
                        add_key(key_idx, rand_color());
                        if (key_idx > fill_guess)
                            fill_guess = key_idx;
                    end
                    if ($urandom_range(0, 7) != 0)
                        add_finish();
                end
            endcase
        end
        add_finish();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_keys.size() != 0 || s_valid)
            @(negedge i_clk);
        while (expected_bins.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0 && expected_bins.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
